// File: sv/rqi_pkg.sv
// Shared widths, types and register codes of the ray/quad intersection block.
package rqi_pkg;

  localparam int CW  = 20;
  localparam int FB  = 8;
  localparam int TF  = 16;
  localparam int EW  = CW + 1;
  localparam int CRW = 2 * EW + 1;
  localparam int PRW = EW + CRW;
  localparam int DW  = PRW + 2;
  localparam int RW  = DW - 1;
  localparam int QW  = CW + TF + 2;
  localparam int PW  = QW + 1 + CW;
  localparam int MW  = PW - TF;
  localparam int SW  = MW + 2;
  localparam int THR_W  = 32;
  localparam int CFG_W  = 3 * CW;
  localparam int CIDX_W = 3;

  typedef enum logic [CIDX_W-1:0] {
    REG_C00 = 3'd0,
    REG_C01 = 3'd1,
    REG_C11 = 3'd2,
    REG_C10 = 3'd3,
    REG_THR = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] x;
  } vec_t;

  typedef struct packed {
    vec_t d;
    vec_t o;
  } ray_t;

  typedef struct packed {
    logic signed [EW-1:0] z;
    logic signed [EW-1:0] y;
    logic signed [EW-1:0] x;
  } evec_t;

  typedef struct packed {
    logic signed [CRW-1:0] z;
    logic signed [CRW-1:0] y;
    logic signed [CRW-1:0] x;
  } cvec_t;

  typedef struct packed {
    logic signed [DW-1:0] det;
    logic signed [DW-1:0] na;
    logic signed [DW-1:0] nb;
    logic signed [DW-1:0] nt;
    logic signed [DW-1:0] det2;
    logic signed [DW-1:0] na2;
    logic signed [DW-1:0] nb2;
  } dots_t;

  typedef struct packed {
    logic          miss;
    logic [RW-1:0] num;
    logic [RW-1:0] den;
  } divreq_t;

  typedef struct packed {
    logic          hit;
    logic [QW-1:0] tq;
  } tres_t;

  localparam logic [PW-1:0] RND = PW'(1) << (TF - 1);
  localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  function automatic evec_t sub_v(vec_t a, vec_t b);
    evec_t r;
    r.x = EW'(a.x) - EW'(b.x);
    r.y = EW'(a.y) - EW'(b.y);
    r.z = EW'(a.z) - EW'(b.z);
    return r;
  endfunction

  function automatic evec_t ext_v(vec_t a);
    evec_t r;
    r.x = EW'(a.x);
    r.y = EW'(a.y);
    r.z = EW'(a.z);
    return r;
  endfunction

  function automatic cvec_t cross_v(evec_t a, evec_t b);
    cvec_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

endpackage

// File: sv/rqi_geom.sv
// Edge, cross-product and dot-product stages of the intersection pipeline.
module rqi_geom import rqi_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_vld,
  input  ray_t  in_ray,
  input  vec_t  c00,
  input  vec_t  c01,
  input  vec_t  c11,
  input  vec_t  c10,
  output logic  out_vld,
  output ray_t  out_ray,
  output dots_t out_dots
);

  logic  v1_r, v2_r, v3_r, v4_r;
  ray_t  ray1_r, ray2_r, ray3_r, ray4_r;
  evec_t d1_r, e01_r, e03_r, e21_r, e23_r, t1_r, t2_r;
  evec_t d2_r, e01b_r, e03b_r, e23b_r, t1b_r, t2b_r;
  cvec_t p1_r, q1_r, p2_r, q2_r;
  logic signed [PRW-1:0] pr_r [7][3];
  dots_t dots_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray1_r <= in_ray;
      d1_r   <= ext_v(in_ray.d);
      e01_r  <= sub_v(c10, c00);
      e03_r  <= sub_v(c01, c00);
      e21_r  <= sub_v(c10, c11);
      e23_r  <= sub_v(c01, c11);
      t1_r   <= sub_v(in_ray.o, c00);
      t2_r   <= sub_v(in_ray.o, c11);

      ray2_r <= ray1_r;
      d2_r   <= d1_r;
      e01b_r <= e01_r;
      e03b_r <= e03_r;
      e23b_r <= e23_r;
      t1b_r  <= t1_r;
      t2b_r  <= t2_r;
      p1_r   <= cross_v(d1_r, e03_r);
      q1_r   <= cross_v(t1_r, e01_r);
      p2_r   <= cross_v(d1_r, e21_r);
      q2_r   <= cross_v(t2_r, e23_r);

      ray3_r <= ray2_r;
      pr_r[0][0] <= e01b_r.x * p1_r.x;
      pr_r[0][1] <= e01b_r.y * p1_r.y;
      pr_r[0][2] <= e01b_r.z * p1_r.z;
      pr_r[1][0] <= t1b_r.x * p1_r.x;
      pr_r[1][1] <= t1b_r.y * p1_r.y;
      pr_r[1][2] <= t1b_r.z * p1_r.z;
      pr_r[2][0] <= d2_r.x * q1_r.x;
      pr_r[2][1] <= d2_r.y * q1_r.y;
      pr_r[2][2] <= d2_r.z * q1_r.z;
      pr_r[3][0] <= e03b_r.x * q1_r.x;
      pr_r[3][1] <= e03b_r.y * q1_r.y;
      pr_r[3][2] <= e03b_r.z * q1_r.z;
      pr_r[4][0] <= e23b_r.x * p2_r.x;
      pr_r[4][1] <= e23b_r.y * p2_r.y;
      pr_r[4][2] <= e23b_r.z * p2_r.z;
      pr_r[5][0] <= t2b_r.x * p2_r.x;
      pr_r[5][1] <= t2b_r.y * p2_r.y;
      pr_r[5][2] <= t2b_r.z * p2_r.z;
      pr_r[6][0] <= d2_r.x * q2_r.x;
      pr_r[6][1] <= d2_r.y * q2_r.y;
      pr_r[6][2] <= d2_r.z * q2_r.z;

      ray4_r      <= ray3_r;
      dots_r.det  <= DW'(pr_r[0][0]) + DW'(pr_r[0][1]) + DW'(pr_r[0][2]);
      dots_r.na   <= DW'(pr_r[1][0]) + DW'(pr_r[1][1]) + DW'(pr_r[1][2]);
      dots_r.nb   <= DW'(pr_r[2][0]) + DW'(pr_r[2][1]) + DW'(pr_r[2][2]);
      dots_r.nt   <= DW'(pr_r[3][0]) + DW'(pr_r[3][1]) + DW'(pr_r[3][2]);
      dots_r.det2 <= DW'(pr_r[4][0]) + DW'(pr_r[4][1]) + DW'(pr_r[4][2]);
      dots_r.na2  <= DW'(pr_r[5][0]) + DW'(pr_r[5][1]) + DW'(pr_r[5][2]);
      dots_r.nb2  <= DW'(pr_r[6][0]) + DW'(pr_r[6][1]) + DW'(pr_r[6][2]);
    end
  end

  assign out_vld  = v4_r;
  assign out_ray  = ray4_r;
  assign out_dots = dots_r;

endmodule

// File: sv/rqi_test.sv
// Sign normalization and accept/reject tests of both triangles.
module rqi_test import rqi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  ray_t             in_ray,
  input  dots_t            in_dots,
  input  logic [THR_W-1:0] thr,
  output logic             out_vld,
  output ray_t             out_ray,
  output divreq_t          out_req
);

  logic                 v5_r, v6_r;
  ray_t                 ray5_r, ray6_r;
  logic signed [DW-1:0] det_r, na_r, nb_r, nt_r;
  logic                 flat1_r, flat2_r, na2n_r, nb2n_r;
  divreq_t              req_r;

  logic signed [DW-1:0] det_a, det2_a, na_n, nb_n, nt_n, na2_n, nb2_n;
  logic                 flat1, flat2, miss;
  logic signed [DW:0]   ab_sum;

  always_comb begin
    det_a  = in_dots.det[DW-1] ? -in_dots.det : in_dots.det;
    na_n   = in_dots.det[DW-1] ? -in_dots.na  : in_dots.na;
    nb_n   = in_dots.det[DW-1] ? -in_dots.nb  : in_dots.nb;
    nt_n   = in_dots.det[DW-1] ? -in_dots.nt  : in_dots.nt;
    det2_a = in_dots.det2[DW-1] ? -in_dots.det2 : in_dots.det2;
    na2_n  = in_dots.det2[DW-1] ? -in_dots.na2  : in_dots.na2;
    nb2_n  = in_dots.det2[DW-1] ? -in_dots.nb2  : in_dots.nb2;
    flat1  = (in_dots.det == '0) ||
             ($unsigned(det_a) < {{(DW-THR_W){1'b0}}, thr});
    flat2  = (in_dots.det2 == '0) ||
             ($unsigned(det2_a) < {{(DW-THR_W){1'b0}}, thr});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v5_r <= in_vld;
      v6_r <= v5_r;
    end
  end

  always_comb begin
    ab_sum = (DW+1)'(na_r) + (DW+1)'(nb_r);
    miss   = flat1_r || na_r[DW-1] || (na_r > det_r) || nb_r[DW-1] || (nb_r > det_r) ||
             ((ab_sum > (DW+1)'(det_r)) && (flat2_r || na2n_r || nb2n_r)) ||
             nt_r[DW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray5_r  <= in_ray;
      det_r   <= det_a;
      na_r    <= na_n;
      nb_r    <= nb_n;
      nt_r    <= nt_n;
      flat1_r <= flat1;
      flat2_r <= flat2;
      na2n_r  <= na2_n[DW-1];
      nb2n_r  <= nb2_n[DW-1];

      ray6_r       <= ray5_r;
      req_r.miss   <= miss;
      req_r.num    <= miss ? '0 : nt_r[RW-1:0];
      req_r.den    <= miss ? RW'(1) : det_r[RW-1:0];
    end
  end

  assign out_vld = v6_r;
  assign out_ray = ray6_r;
  assign out_req = req_r;

endmodule

// File: sv/rqi_div.sv
// Pipelined restoring divider producing the fixed-point ray distance.
module rqi_div import rqi_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    in_vld,
  input  ray_t    in_ray,
  input  divreq_t in_req,
  output logic    out_vld,
  output ray_t    out_ray,
  output tres_t   out_res
);

  logic          v_r     [QW];
  logic [RW-1:0] rem_r   [QW];
  logic [RW-1:0] den_r   [QW];
  logic [QW-1:0] low_r   [QW];
  logic [QW-1:0] q_r     [QW];
  logic          miss_r  [QW];
  logic          clamp_r [QW];
  ray_t          ray_r   [QW];

  logic [RW-1:0] rem0;
  logic [QW-1:0] low0;

  assign rem0 = RW'(in_req.num >> (QW - TF));
  assign low0 = {in_req.num[QW-TF-1:0], {TF{1'b0}}};

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic          v_p, miss_p, clamp_p;
    logic [RW-1:0] rem_p, den_p;
    logic [QW-1:0] low_p, q_p;
    ray_t          ray_p;
    logic [RW:0]   trial, diff;
    logic          ge;

    if (k == 0) begin : g_head
      assign v_p     = in_vld;
      assign rem_p   = rem0;
      assign den_p   = in_req.den;
      assign low_p   = low0;
      assign q_p     = '0;
      assign miss_p  = in_req.miss;
      assign clamp_p = rem0 >= in_req.den;
      assign ray_p   = in_ray;
    end else begin : g_body
      assign v_p     = v_r[k-1];
      assign rem_p   = rem_r[k-1];
      assign den_p   = den_r[k-1];
      assign low_p   = low_r[k-1];
      assign q_p     = q_r[k-1];
      assign miss_p  = miss_r[k-1];
      assign clamp_p = clamp_r[k-1];
      assign ray_p   = ray_r[k-1];
    end

    assign trial = {rem_p, low_p[QW-1]};
    assign diff  = trial - {1'b0, den_p};
    assign ge    = trial >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]   <= ge ? diff[RW-1:0] : trial[RW-1:0];
        low_r[k]   <= low_p << 1;
        q_r[k]     <= {q_p[QW-2:0], ge};
        den_r[k]   <= den_p;
        miss_r[k]  <= miss_p;
        clamp_r[k] <= clamp_p;
        ray_r[k]   <= ray_p;
      end
    end
  end

  always_comb begin
    out_res.tq  = clamp_r[QW-1] ? {QW{1'b1}} : q_r[QW-1];
    out_res.hit = !miss_r[QW-1] && (out_res.tq != '0);
  end

  assign out_vld = v_r[QW-1];
  assign out_ray = ray_r[QW-1];

endmodule

// File: sv/rqi_place.sv
// Hit point stages: scale direction by distance, round, add origin, saturate.
module rqi_place import rqi_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  ray_t          in_ray,
  input  tres_t         in_res,
  output logic          out_vld,
  output logic          out_hit,
  output vec_t          out_pt
);

  logic                 va_r, vb_r, vc_r;
  logic                 hita_r, hitb_r, hitc_r;
  vec_t                 oa_r, ob_r, pt_r;
  logic signed [PW-1:0] px_r, py_r, pz_r;
  logic [MW-1:0]        mx_r, my_r, mz_r;
  logic                 nx_r, ny_r, nz_r;

  function automatic logic [MW-1:0] round_mag(logic signed [PW-1:0] p);
    logic [PW-1:0] am, s;
    am = p[PW-1] ? -p : p;
    s  = am + RND;
    return s[PW-1:TF];
  endfunction

  function automatic logic signed [CW-1:0] sat(logic signed [CW-1:0] o, logic [MW-1:0] m,
                                               logic neg);
    logic signed [SW-1:0] om, s;
    om = $signed({2'b00, m});
    s  = neg ? SW'(o) - om : SW'(o) + om;
    if (s > SAT_HI) begin
      s = SAT_HI;
    end else if (s < SAT_LO) begin
      s = SAT_LO;
    end
    return s[CW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_vld;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hita_r <= in_res.hit;
      oa_r   <= in_ray.o;
      px_r   <= $signed({1'b0, in_res.tq}) * in_ray.d.x;
      py_r   <= $signed({1'b0, in_res.tq}) * in_ray.d.y;
      pz_r   <= $signed({1'b0, in_res.tq}) * in_ray.d.z;

      hitb_r <= hita_r;
      ob_r   <= oa_r;
      mx_r   <= round_mag(px_r);
      my_r   <= round_mag(py_r);
      mz_r   <= round_mag(pz_r);
      nx_r   <= px_r[PW-1];
      ny_r   <= py_r[PW-1];
      nz_r   <= pz_r[PW-1];

      hitc_r <= hitb_r;
      pt_r.x <= hitb_r ? sat(ob_r.x, mx_r, nx_r) : '0;
      pt_r.y <= hitb_r ? sat(ob_r.y, my_r, ny_r) : '0;
      pt_r.z <= hitb_r ? sat(ob_r.z, mz_r, nz_r) : '0;
    end
  end

  assign out_vld = vc_r;
  assign out_hit = hitc_r;
  assign out_pt  = pt_r;

endmodule

// File: sv/ray_quad_intersect_top.sv
// Top level of the ray/quadrilateral intersection pipeline.
// Pipeline: 4 geometry, 2 test, 38 divider and 3 hit point stages from input word
// accept to out_tvalid; the 38 divider stages come from one distance bit each.
// Throughput: one ray per cycle; a stalled output freezes the whole pipeline.
// Reset (rst_n low, synchronous): all stage valid bits clear, corners clear to
// zero, determinant threshold set to one.
module ray_quad_intersect_top import rqi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [6*CW-1:0]   in_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,  // point_x, point_y, point_z, zero pad
  output logic              out_tuser,  // hit
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_data
);

  vec_t             c00_r, c01_r, c11_r, c10_r;
  logic [THR_W-1:0] thr_r;
  logic             en;

  logic    g_vld, t_vld, d_vld, p_vld, p_hit;
  ray_t    g_ray, t_ray, d_ray;
  dots_t   g_dots;
  divreq_t t_req;
  tres_t   d_res;
  vec_t    p_pt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c00_r <= '0;
      c01_r <= '0;
      c11_r <= '0;
      c10_r <= '0;
      thr_r <= THR_W'(1);
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_addr))
        REG_C00: c00_r <= vec_t'(cfg_data);
        REG_C01: c01_r <= vec_t'(cfg_data);
        REG_C11: c11_r <= vec_t'(cfg_data);
        REG_C10: c10_r <= vec_t'(cfg_data);
        REG_THR: thr_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign en        = !p_vld || out_tready;
  assign in_tready = en;

  rqi_geom u_geom (
    .clk, .rst_n, .en,
    .in_vld   (in_tvalid && in_tready),
    .in_ray   (ray_t'(in_tdata)),
    .c00      (c00_r),
    .c01      (c01_r),
    .c11      (c11_r),
    .c10      (c10_r),
    .out_vld  (g_vld),
    .out_ray  (g_ray),
    .out_dots (g_dots)
  );

  rqi_test u_test (
    .clk, .rst_n, .en,
    .in_vld  (g_vld),
    .in_ray  (g_ray),
    .in_dots (g_dots),
    .thr     (thr_r),
    .out_vld (t_vld),
    .out_ray (t_ray),
    .out_req (t_req)
  );

  rqi_div u_div (
    .clk, .rst_n, .en,
    .in_vld  (t_vld),
    .in_ray  (t_ray),
    .in_req  (t_req),
    .out_vld (d_vld),
    .out_ray (d_ray),
    .out_res (d_res)
  );

  rqi_place u_place (
    .clk, .rst_n, .en,
    .in_vld  (d_vld),
    .in_ray  (d_ray),
    .in_res  (d_res),
    .out_vld (p_vld),
    .out_hit (p_hit),
    .out_pt  (p_pt)
  );

  assign out_tvalid = p_vld;
  assign out_tuser  = p_hit;
  assign out_tdata  = {{(64-CFG_W){1'b0}}, p_pt};

endmodule

// File: sv/rqi_check.sv
// Port-level checker for the intersection block, bound to the top level.
module rqi_check import rqi_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [6*CW-1:0]   in_tdata,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [63:0]       out_tdata,
  input logic              out_tuser,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [CIDX_W-1:0] cfg_addr,
  input logic [CFG_W-1:0]  cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss word carries a nonzero point");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind ray_quad_intersect_top rqi_check u_rqi_check (.*);
